FILE: sv/linear_interp_resampler_macros.svh
// ----------------------------------------------------------------------------
// linear_interp_resampler_macros.svh
// Assertion macros for the linear interpolation resampler.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_MACROS_SVH

// same-cycle implication
`define LIR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lir assertion failed");

// next-cycle implication
`define LIR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lir assertion failed");

`endif

FILE: sv/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Shared constants, types and state encodings of the resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int RATE_W      = 18;
  localparam int OUT_RATE    = 16000;
  localparam int RATE_RESET  = 16000;

  localparam int POS_W  = FRAC_BITS + 5;
  localparam int STEP_W = FRAC_BITS + 4;
  localparam int QUO_W  = STEP_W + 1;
  localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

  // 16000 = 125 << 7: step = ((rate << (F - 7)) + 62) / 125, by reciprocal
  localparam int RATE_SH      = 7;
  localparam int RATE_ODD     = OUT_RATE >> RATE_SH;
  localparam int STEP_NUM_W   = RATE_W + FRAC_BITS - RATE_SH;
  localparam int RECIP_SH     = STEP_NUM_W + RATE_SH;
  localparam int RECIP_W      = RECIP_SH - 6;
  localparam int RECIP_PROD_W = STEP_NUM_W + RECIP_W;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_INPUT_RATE = REG_IDX_W'(0);

  localparam logic [POS_W-1:0]  ONE_POS    = POS_W'(64'd1 << FRAC_BITS);
  localparam logic [POS_W-1:0]  TWO_POS    = POS_W'(64'd2 << FRAC_BITS);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64'd1 << FRAC_BITS);
  localparam logic [QUO_W-1:0]  STEP_MIN   = QUO_W'(64'd1 << (FRAC_BITS - 2));
  localparam logic [QUO_W-1:0]  STEP_MAX   = QUO_W'((64'd1 << STEP_W) - 64'd1);
  localparam logic [RATE_W-1:0] RATE_RST_V = RATE_W'(RATE_RESET);
  localparam logic [PROD_W-1:0] ROUND_C    = PROD_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(RATE_ODD) - 64'd1) / 64'(RATE_ODD));
  localparam logic [STEP_NUM_W-1:0] STEP_RND = STEP_NUM_W'(RATE_ODD / 2);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    sample_t prev;
    sample_t cur;
    logic    interp;
    logic    eos;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_EMIT
  } bk_state_t;

endpackage

FILE: sv/lir_step.sv
// ----------------------------------------------------------------------------
// lir_step
// Rate register and step by reciprocal multiply: round(rate * 2^F / 16000), clamped.
// ----------------------------------------------------------------------------
module lir_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [lir_pkg::RATE_W-1:0]    wr_rate,
  output logic [lir_pkg::RATE_W-1:0]    rate,
  output lir_pkg::step_t                step,
  output logic                          busy
);

  logic [lir_pkg::RATE_W-1:0]       rate_r;
  lir_pkg::step_t                   step_r, step_nxt;
  logic                             busy_r;

  logic [lir_pkg::STEP_NUM_W-1:0]   num;
  logic [lir_pkg::RECIP_PROD_W-1:0] prod;
  logic [lir_pkg::QUO_W-1:0]        quo;

  assign num  = {rate_r, {(lir_pkg::FRAC_BITS - lir_pkg::RATE_SH){1'b0}}}
              + lir_pkg::STEP_RND;
  assign prod = lir_pkg::RECIP_PROD_W'(num)
              * lir_pkg::RECIP_PROD_W'(lir_pkg::RECIP_MUL);
  assign quo  = prod[lir_pkg::RECIP_SH +: lir_pkg::QUO_W];

  always_comb begin
    if (quo > lir_pkg::STEP_MAX) begin
      step_nxt = lir_pkg::STEP_MAX[lir_pkg::STEP_W-1:0];
    end else if (quo < lir_pkg::STEP_MIN) begin
      step_nxt = lir_pkg::STEP_MIN[lir_pkg::STEP_W-1:0];
    end else begin
      step_nxt = quo[lir_pkg::STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= lir_pkg::RATE_RST_V;
      step_r <= lir_pkg::STEP_RESET;
      busy_r <= 1'b0;
    end else if (wr_en) begin
      rate_r <= wr_rate;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      step_r <= step_nxt;
      busy_r <= 1'b0;
    end
  end

  assign rate = rate_r;
  assign step = step_r;
  assign busy = busy_r;

endmodule

FILE: sv/lir_front.sv
// ----------------------------------------------------------------------------
// lir_front
// Input side: tracks the previous sample and queues all beats except a first sample without end of stream.
// ----------------------------------------------------------------------------
module lir_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lir_pkg::sample_t  in_sample_in,
  input  logic              in_end_of_stream,
  input  lir_pkg::q_stat_t  q_stat,
  input  logic              step_busy,
  output logic              push,
  output lir_pkg::q_entry_t push_ent
);

  lir_pkg::sample_t prev_r;
  logic             have_prev_r;
  logic             accept;

  assign in_ready = !q_stat.full && !step_busy;
  assign accept   = in_valid && in_ready;

  // a first sample without end of stream is only stored
  assign push = accept && (have_prev_r || in_end_of_stream);

  assign push_ent.prev   = prev_r;
  assign push_ent.cur    = in_sample_in;
  assign push_ent.interp = have_prev_r;
  assign push_ent.eos    = in_end_of_stream;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
    end else if (accept) begin
      prev_r      <= in_end_of_stream ? '0 : in_sample_in;
      have_prev_r <= !in_end_of_stream;
    end
  end

endmodule

FILE: sv/lir_queue.sv
// ----------------------------------------------------------------------------
// lir_queue
// Small flop queue between front and back.
// ----------------------------------------------------------------------------
module lir_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lir_pkg::q_entry_t push_ent,
  input  logic              pop,
  output lir_pkg::q_entry_t head,
  output lir_pkg::q_stat_t  stat
);

  lir_pkg::q_entry_t         ent_r [lir_pkg::QDEPTH];
  logic [lir_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [lir_pkg::QPTR_W:0]   cnt_r;

  assign head       = ent_r[rd_ptr_r];
  assign stat.full  = cnt_r == (lir_pkg::QPTR_W + 1)'(lir_pkg::QDEPTH);
  assign stat.empty = cnt_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: sv/lir_back.sv
// ----------------------------------------------------------------------------
// lir_back
// Output side: walks the output position, interpolates, drives results.
// ----------------------------------------------------------------------------
module lir_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lir_pkg::q_entry_t head,
  input  lir_pkg::q_stat_t  q_stat,
  output logic              pop,
  input  lir_pkg::step_t    step,
  output logic              out_valid,
  input  logic              out_ready,
  output lir_pkg::sample_t  out_sample_out,
  output logic              out_run_last
);

  localparam int S = lir_pkg::SAMPLE_BITS;
  localparam int F = lir_pkg::FRAC_BITS;

  lir_pkg::bk_state_t state_r, state_nxt;
  lir_pkg::q_entry_t  ent_r;
  logic               tail_r;
  lir_pkg::pos_t      pos_r;
  logic signed [lir_pkg::PROD_W-1:0] prod_r;
  logic               last_r;
  logic               out_valid_r;
  lir_pkg::sample_t   out_sample_r;
  logic               out_last_r;

  logic               pos_ge_one;
  lir_pkg::pos_t      sum;
  logic               sum_last;
  logic signed [S:0]  diff;
  logic signed [F:0]  frac;
  logic signed [lir_pkg::PROD_W-1:0] prod_c;
  logic signed [lir_pkg::PROD_W-1:0] rsum;
  lir_pkg::sample_t   interp_val;

  logic do_wrap, do_done, do_calc, do_load;

  assign pos_ge_one = pos_r >= lir_pkg::ONE_POS;
  assign sum        = pos_r + lir_pkg::POS_W'(step);
  assign sum_last   = tail_r ? (sum >= lir_pkg::ONE_POS)
                             : (sum >= lir_pkg::ONE_POS)
                               && (!ent_r.eos || sum >= lir_pkg::TWO_POS);

  assign diff   = $signed({ent_r.cur[S-1], ent_r.cur}) - $signed({ent_r.prev[S-1], ent_r.prev});
  assign frac   = $signed({1'b0, pos_r[F-1:0]});
  assign prod_c = diff * frac;

  // ties round up: floor((d*frac + half) / 2^F)
  assign rsum       = prod_r + $signed(lir_pkg::ROUND_C);
  assign interp_val = ent_r.prev + $signed(rsum[F +: S]);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lir_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = lir_pkg::BK_CALC;
        end
      end
      lir_pkg::BK_CALC: begin
        if (do_calc) begin
          state_nxt = lir_pkg::BK_EMIT;
        end else if (do_done) begin
          state_nxt = lir_pkg::BK_IDLE;
        end
      end
      lir_pkg::BK_EMIT: begin
        if (do_load) begin
          state_nxt = lir_pkg::BK_CALC;
        end
      end
      default: state_nxt = lir_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop     = 1'b0;
    do_wrap = 1'b0;
    do_done = 1'b0;
    do_calc = 1'b0;
    do_load = 1'b0;
    unique case (state_r)
      lir_pkg::BK_IDLE: begin
        pop = !q_stat.empty;
      end
      lir_pkg::BK_CALC: begin
        priority if (!tail_r && pos_ge_one) begin
          do_wrap = 1'b1;
        end else if (tail_r && !(ent_r.eos && !pos_ge_one)) begin
          do_done = 1'b1;
        end else begin
          do_calc = 1'b1;
        end
      end
      lir_pkg::BK_EMIT: begin
        do_load = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= head;
    end
    if (do_calc) begin
      prod_r <= prod_c;
      last_r <= sum_last;
    end
    if (do_load) begin
      out_sample_r <= tail_r ? ent_r.cur : interp_val;
      out_last_r   <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lir_pkg::BK_IDLE;
      tail_r      <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        tail_r <= !head.interp;
      end
      if (do_wrap) begin
        pos_r  <= pos_r - lir_pkg::ONE_POS;
        tail_r <= 1'b1;
      end
      if (do_calc) begin
        pos_r <= sum;
      end
      if (do_done && ent_r.eos) begin
        pos_r <= '0;
      end
      if (do_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_run_last   = out_last_r;

endmodule

FILE: sv/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Linear interpolation resampler to 16 kHz with APB rate register.
//
//   channel   dir  handshake          payload
//   in        in   in_valid/in_ready  in_sample_in, in_end_of_stream
//   out       out  out_valid/out_ready out_sample_out, out_run_last
//   cfg       in   psel/penable/pready paddr, pwdata, prdata (input_rate @ 0x0)
//
// Each result passes through the back-end states BK_CALC (position step and
// multiply into prod_r) and BK_EMIT (rounding add into the output register),
// which waits on out_ready while an earlier result is still unaccepted.
// A rate write loads the rate register and sets busy; while busy, the step is
// rebuilt by a reciprocal multiply and in_ready is low.
// Reset is synchronous: rate 16000 Hz, unity step, stream state cleared.
// A 2-beat queue lets input beats land while results wait on out_ready.
// ----------------------------------------------------------------------------
`include "linear_interp_resampler_macros.svh"

module linear_interp_resampler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [15:0]             in_sample_in,
  input  logic                           in_end_of_stream,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             out_sample_out,
  output logic                           out_run_last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lir_pkg::ADDR_W-1:0]     paddr,
  input  logic [lir_pkg::DATA_W-1:0]     pwdata,
  output logic [lir_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  logic                       rate_hit;
  logic                       rate_wr;
  logic [lir_pkg::RATE_W-1:0] rate;
  lir_pkg::step_t             step;
  logic                       step_busy;
  lir_pkg::q_stat_t           q_stat;
  lir_pkg::q_entry_t          push_ent, head;
  logic                       push, pop;

  assign pready   = 1'b1;
  assign rate_hit = paddr[lir_pkg::ADDR_W-1:2] == lir_pkg::REG_INPUT_RATE;
  assign rate_wr  = psel && penable && pwrite && pready && rate_hit;
  assign prdata   = rate_hit ? lir_pkg::DATA_W'(rate) : '0;

  lir_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rate_wr),
    .wr_rate (pwdata[lir_pkg::RATE_W-1:0]),
    .rate    (rate),
    .step    (step),
    .busy    (step_busy)
  );

  lir_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_in     (in_sample_in),
    .in_end_of_stream (in_end_of_stream),
    .q_stat           (q_stat),
    .step_busy        (step_busy),
    .push             (push),
    .push_ent         (push_ent)
  );

  lir_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  lir_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .step           (step),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_run_last   (out_run_last)
  );

  `LIR_ASSERT_NXT(a_rate_wr_blocks_in, rate_wr, !in_ready)
  `LIR_ASSERT_IMP(a_no_push_when_full, q_stat.full, !push)
  `LIR_ASSERT_IMP(a_pop_needs_entry, pop, !q_stat.empty)

endmodule

FILE: tb/tb_linear_interp_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_interp_resampler
// Self-checking bench for the 16 kHz linear interpolation resampler.
//
// Directed beats cover full-scale samples, the first sample of a stream,
// end of stream, pass-through at 16 kHz, the slowest and fastest steps,
// clamped rates, ignored register writes and a rate change mid-stream.
// Random streams follow under random rates. Both channels idle at random,
// and the output side holds off once long enough to back up the input.
// A scoreboard tracks position and step and checks every output beat
// in order.
// ----------------------------------------------------------------------------
module tb_linear_interp_resampler;

  localparam int     CLK_PERIOD   = 4;
  localparam int     RANDOM_ITEMS = 140;
  localparam int     MAX_RESULTS  = 8;
  localparam int     DRAIN_CYCLES = 60;
  localparam int     HOLD_AT      = 30;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     WATCH_LIMIT  = 4000;
  localparam longint UNIT_POS     = longint'(1) << lir_pkg::FRAC_BITS;
  localparam longint HALF_UNIT    = UNIT_POS / 2;
  localparam longint STEP_LO      = UNIT_POS / 4;
  localparam longint STEP_HI      = (UNIT_POS << 4) - 1;

  localparam logic [lir_pkg::REG_IDX_W-1:0] REG_SPARE = lir_pkg::REG_IDX_W'(1);
  localparam logic [lir_pkg::ADDR_W-1:0] RATE_ADDR  = {lir_pkg::REG_INPUT_RATE, 2'b00};
  localparam logic [lir_pkg::ADDR_W-1:0] SPARE_ADDR = {REG_SPARE, 2'b00};

  localparam lir_pkg::sample_t EDGE_SAMPLES [0:3] = '{
    lir_pkg::sample_t'(16'h7FFF), lir_pkg::sample_t'(16'h8000),
    lir_pkg::sample_t'(16'h0000), lir_pkg::sample_t'(16'hFFFF)};
  localparam int COMMON_RATES [0:5] = '{8000, 11025, 22050, 32000, 44100, 48000};

  typedef struct {
    lir_pkg::sample_t value;
    logic             last;
  } resampled_t;

  class resample_scoreboard;
    lir_pkg::sample_t last_in;
    bit               have_last;
    longint           pos;
    longint           step;
    int               errors;
    resampled_t       pending_out[$];

    function new();
      last_in   = '0;
      have_last = 1'b0;
      pos       = 0;
      errors    = 0;
      set_step(lir_pkg::RATE_W'(lir_pkg::RATE_RESET));
    endfunction

    function void set_step(logic [lir_pkg::RATE_W-1:0] rate);
      longint q;
      q = ((longint'(rate) << lir_pkg::FRAC_BITS) + lir_pkg::OUT_RATE / 2)
          / lir_pkg::OUT_RATE;
      if (q < STEP_LO) q = STEP_LO;
      if (q > STEP_HI) q = STEP_HI;
      step = q;
    endfunction

    function void write_reg(logic [lir_pkg::ADDR_W-1:0] addr,
                            logic [lir_pkg::DATA_W-1:0] data);
      if (addr[lir_pkg::ADDR_W-1:2] == lir_pkg::REG_INPUT_RATE) begin
        set_step(data[lir_pkg::RATE_W-1:0]);
      end
    endfunction

    function lir_pkg::sample_t interpolate(lir_pkg::sample_t base,
                                           lir_pkg::sample_t target, longint frac);
      longint span;
      longint acc;
      span = longint'(target) - longint'(base);
      acc  = span * frac + HALF_UNIT;
      return lir_pkg::sample_t'(longint'(base) + (acc >>> lir_pkg::FRAC_BITS));
    endfunction

    function void accept_sample(lir_pkg::sample_t cur, logic eos);
      lir_pkg::sample_t made[$];
      resampled_t       r;
      if (have_last) begin
        while (pos < UNIT_POS && made.size() < MAX_RESULTS) begin
          made.push_back(interpolate(last_in, cur, pos));
          pos += step;
        end
        pos -= UNIT_POS;
      end
      if (eos) begin
        // tail: everything short of one sample past the end repeats it
        while (pos < UNIT_POS && made.size() < MAX_RESULTS) begin
          made.push_back(cur);
          pos += step;
        end
        last_in   = '0;
        have_last = 1'b0;
        pos       = 0;
      end else begin
        last_in   = cur;
        have_last = 1'b1;
      end
      foreach (made[i]) begin
        r.value = made[i];
        r.last  = (i == made.size() - 1);
        pending_out.push_back(r);
      end
    endfunction

    function void check_output(lir_pkg::sample_t got, logic got_last);
      resampled_t want;
      if (pending_out.size() == 0) begin
        $display("%0t unexpected output beat: expected none, got sample %0d last %0b",
                 $time, got, got_last);
        errors++;
        return;
      end
      want = pending_out.pop_front();
      if (got !== want.value) begin
        $display("%0t sample_out: expected %0d, got %0d", $time, want.value, got);
        errors++;
      end
      if (got_last !== want.last) begin
        $display("%0t run_last: expected %0b, got %0b", $time, want.last, got_last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_out.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  lir_pkg::sample_t           in_sample_in;
  logic                       in_end_of_stream;
  logic                       out_valid;
  logic                       out_ready;
  lir_pkg::sample_t           out_sample_out;
  logic                       out_run_last;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [lir_pkg::ADDR_W-1:0] paddr;
  logic [lir_pkg::DATA_W-1:0] pwdata;
  logic [lir_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  resample_scoreboard sb = new();

  int                         in_beats = 0;
  int                         out_beats = 0;
  int                         quiet_cycles = 0;
  int                         rate_writes = 0;
  int                         reg_errors = 0;
  int                         random_sent = 0;
  bit                         tx_steady = 1'b0;
  logic [lir_pkg::DATA_W-1:0] rate_shadow = lir_pkg::DATA_W'(lir_pkg::RATE_RESET);

  linear_interp_resampler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_in     (in_sample_in),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_out   (out_sample_out),
    .out_run_last     (out_run_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        sb.write_reg(paddr, pwdata);
      end
      if (in_valid && in_ready) begin
        sb.accept_sample(in_sample_in, in_end_of_stream);
        in_beats <= in_beats + 1;
      end
      if (out_valid && out_ready) begin
        sb.check_output(out_sample_out, out_run_last);
        out_beats <= out_beats + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCH_LIMIT) begin
      $display("%0t timeout: no beat moved for %0d cycles", $time, WATCH_LIMIT);
      $display("linear_interp_resampler: mismatch");
      $finish;
    end
  end

  // output side: random stalls, one long hold-off to back up the input
  initial begin : receiver
    int unsigned gap;
    bit          held;
    bit          rx_steady;
    held      = 1'b0;
    rx_steady = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && in_beats >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic reg_write(input logic [lir_pkg::ADDR_W-1:0] addr,
                           input logic [lir_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read_check(input logic [lir_pkg::ADDR_W-1:0] addr,
                                input logic [lir_pkg::DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t input_rate readback: expected %0d, got %0d", $time, want, prdata);
      reg_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rate(input logic [lir_pkg::DATA_W-1:0] value);
    reg_write(RATE_ADDR, value);
    rate_shadow = lir_pkg::DATA_W'(value[lir_pkg::RATE_W-1:0]);
    rate_writes++;
    reg_read_check(RATE_ADDR, rate_shadow);
  endtask

  task automatic send(input lir_pkg::sample_t s, input logic eos);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_sample_in     <= s;
    in_end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait out all outputs, then the queued beats that make none
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_rate();
    int r;
    case ($urandom_range(0, 5))
      0: r = $urandom_range(4000, 192000);
      1: r = 4000;
      2: r = 192000;
      3: r = $urandom_range(0, 262143);
      4: r = COMMON_RATES[$urandom_range(0, 5)];
      default: r = lir_pkg::OUT_RATE;
    endcase
    return r;
  endfunction

  task automatic random_stream(input int len, input bit close);
    lir_pkg::sample_t s;
    lir_pkg::sample_t recent;
    int               v;
    logic             eos;
    recent = '0;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1: s = EDGE_SAMPLES[$urandom_range(0, 3)];
        2, 3, 4: begin
          v = int'(recent) + int'($urandom_range(0, 512)) - 256;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          s = lir_pkg::sample_t'(v);
        end
        default: s = lir_pkg::sample_t'($urandom);
      endcase
      eos = (close && i == len - 1) || ($urandom_range(0, 29) == 0);
      send(s, eos);
      recent = s;
      random_sent++;
    end
  endtask

  initial begin : stimulus
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_sample_in     <= '0;
    in_end_of_stream <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_read_check(RATE_ADDR, rate_shadow);

    // unity step: samples pass through one beat late
    send(lir_pkg::sample_t'(32767), 1'b0);
    send(lir_pkg::sample_t'(-32768), 1'b0);
    send(lir_pkg::sample_t'(0), 1'b0);
    send(lir_pkg::sample_t'(-1), 1'b0);
    send(lir_pkg::sample_t'(1), 1'b1);
    send(lir_pkg::sample_t'(-32768), 1'b1);

    // slowest step, full-scale swings, eight outputs on the closing beat
    drain();
    set_rate(4000);
    send(lir_pkg::sample_t'(-32768), 1'b0);
    send(lir_pkg::sample_t'(32767), 1'b0);
    send(lir_pkg::sample_t'(-32768), 1'b0);
    send(lir_pkg::sample_t'(12345), 1'b1);

    // write to an unused register must not touch the rate
    drain();
    reg_write(SPARE_ADDR, 48000);
    reg_read_check(RATE_ADDR, rate_shadow);
    send(lir_pkg::sample_t'(100), 1'b0);
    send(lir_pkg::sample_t'(-101), 1'b1);

    // fastest nominal step, then a rate change with the stream still open
    drain();
    set_rate(192000);
    send(lir_pkg::sample_t'(1000), 1'b0);
    send(lir_pkg::sample_t'(-2000), 1'b0);
    send(lir_pkg::sample_t'(3000), 1'b0);
    send(lir_pkg::sample_t'(-4000), 1'b0);
    drain();
    set_rate(44100);
    send(lir_pkg::sample_t'(7), 1'b0);
    send(lir_pkg::sample_t'(-7), 1'b0);
    send(lir_pkg::sample_t'(32767), 1'b1);

    // step saturates high, then clamps low
    drain();
    set_rate(262143);
    send(lir_pkg::sample_t'(-5), 1'b0);
    send(lir_pkg::sample_t'(5), 1'b0);
    send(lir_pkg::sample_t'(9), 1'b1);
    drain();
    set_rate(1000);
    send(lir_pkg::sample_t'(-32768), 1'b0);
    send(lir_pkg::sample_t'(32767), 1'b1);

    // random streams; the first one runs into the output hold-off
    drain();
    set_rate(8000);
    random_stream(20, 1'b1);
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      if ($urandom_range(0, 7) == 0) begin
        reg_write(SPARE_ADDR, $urandom);
      end
      set_rate(pick_rate());
      random_stream($urandom_range(1, 20), $urandom_range(0, 4) != 0);
    end
    drain();

    $display("run covered %0d input beats and %0d output beats over %0d rate writes",
             in_beats, out_beats, rate_writes);
    $display("incl. pass-through, clamped steps, mid-stream rate change, output back-pressure");
    if (sb.errors == 0 && reg_errors == 0 && sb.pending() == 0) begin
      $display("linear_interp_resampler: match");
    end else begin
      $display("linear_interp_resampler: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/lir_pkg.sv
sv/lir_step.sv
sv/lir_front.sv
sv/lir_queue.sv
sv/lir_back.sv
sv/linear_interp_resampler.sv
tb/tb_linear_interp_resampler.sv
